### hw/rtl/cnep_pkg.sv
// ----------------------------------------------------------------------------
// cnep_pkg
// Types, constants and small lookup functions shared by the cpio newc entry
// parser modules.
// ----------------------------------------------------------------------------
package cnep_pkg;

  // Header layout of a newc entry.
  localparam int unsigned HeaderBytes   = 110;
  localparam int unsigned HeaderPosW    = 7;
  localparam int unsigned MagicLen      = 6;
  localparam int unsigned DigitsPerFld  = 8;
  localparam int unsigned FieldMode     = 1;
  localparam int unsigned FieldFileSize = 6;
  localparam int unsigned FieldNameSize = 11;

  // Four-byte alignment of names and file data.
  localparam int unsigned AlignW        = 2;
  localparam logic [AlignW-1:0] HeaderAlign = AlignW'(HeaderBytes % 4);

  // Name comparison.
  localparam int unsigned MaxNameBytes  = 16;
  localparam int unsigned TrailerLen    = 10;
  localparam int unsigned TargetLenW    = 5;
  localparam int unsigned NameCmpLen    =
      ((MaxNameBytes > TrailerLen) ? MaxNameBytes : TrailerLen) + 1;
  localparam int unsigned NamePosW      = $clog2(NameCmpLen + 1);

  localparam int unsigned SizeW         = 32;
  localparam logic [3:0]  ModeTypeDir   = 4'h4;

  typedef enum logic [2:0] {
    PhHeader  = 3'd0,
    PhName    = 3'd1,
    PhNamePad = 3'd2,
    PhData    = 3'd3,
    PhDataPad = 3'd4,
    PhStop    = 3'd5
  } phase_e;

  typedef enum logic [2:0] {
    ClsHeader  = 3'd0,
    ClsName    = 3'd1,
    ClsNamePad = 3'd2,
    ClsData    = 3'd3,
    ClsDataPad = 3'd4,
    ClsIgnored = 3'd5
  } byte_class_e;

  typedef enum logic [1:0] {
    StParsing  = 2'd0,
    StBadMagic = 2'd1,
    StTrailer  = 2'd2,
    StBadHex   = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    FldMode     = 2'd0,
    FldFileSize = 2'd1,
    FldNameSize = 2'd2
  } hex_field_e;

  typedef enum logic [1:0] {
    CfgTargetLow  = 2'd0,
    CfgTargetHigh = 2'd1,
    CfgTargetLen  = 2'd2
  } cfg_index_e;

  // Decoded view of one header byte.
  typedef struct packed {
    logic       magic_bad;
    logic       hex_field;
    logic       hex_bad;
    logic       first_digit;
    logic       last_digit;
    hex_field_e fld;
    logic [3:0] nibble;
  } hdr_dec_t;

  // Per-byte name comparison outcome.
  typedef struct packed {
    logic target_miss;
    logic trailer_miss;
  } name_cmp_t;

  // One result item.
  typedef struct packed {
    byte_class_e      cls;
    logic [7:0]       data_byte;
    logic             entry_done;
    logic             name_match;
    logic             is_directory;
    logic [SizeW-1:0] file_size;
    logic [SizeW-1:0] name_size;
    status_e          status;
  } parse_res_t;

  function automatic logic [7:0] magic_char(input logic [2:0] idx);
    logic [7:0] c;
    unique case (idx)
      3'd0:    c = 8'h30;
      3'd1:    c = 8'h37;
      3'd2:    c = 8'h30;
      3'd3:    c = 8'h37;
      3'd4:    c = 8'h30;
      3'd5:    c = 8'h31;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  function automatic logic [7:0] trailer_char(input logic [3:0] idx);
    logic [7:0] c;
    unique case (idx)
      4'd0:    c = 8'h54;
      4'd1:    c = 8'h52;
      4'd2:    c = 8'h41;
      4'd3:    c = 8'h49;
      4'd4:    c = 8'h4C;
      4'd5:    c = 8'h45;
      4'd6:    c = 8'h52;
      4'd7:    c = 8'h21;
      4'd8:    c = 8'h21;
      4'd9:    c = 8'h21;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  // Returns {invalid, value} for one ASCII hex digit.
  function automatic logic [4:0] hex_value(input logic [7:0] c);
    logic [4:0] v;
    if (c >= 8'h30 && c <= 8'h39) begin
      v = {1'b0, 4'(c - 8'h30)};
    end else if (c >= 8'h41 && c <= 8'h46) begin
      v = {1'b0, 4'(c - 8'h37)};
    end else if (c >= 8'h61 && c <= 8'h66) begin
      v = {1'b0, 4'(c - 8'h57)};
    end else begin
      v = 5'h10;
    end
    return v;
  endfunction

endpackage

### hw/rtl/cnep_hdr_dec.sv
// ----------------------------------------------------------------------------
// cnep_hdr_dec
// Classifies one header byte by its position: magic check, and hex digit
// decode for the mode, file size and name size fields.
// ----------------------------------------------------------------------------
module cnep_hdr_dec (
  input  logic [cnep_pkg::HeaderPosW-1:0] pos_i,
  input  logic [7:0]                      byte_i,
  output cnep_pkg::hdr_dec_t              dec_o
);

  logic [cnep_pkg::HeaderPosW-1:0] off;
  logic [cnep_pkg::HeaderPosW-4:0] field;
  logic [2:0]                      digit;
  logic [4:0]                      hv;
  logic                            in_magic;

  assign in_magic = pos_i < cnep_pkg::HeaderPosW'(cnep_pkg::MagicLen);
  assign off      = pos_i - cnep_pkg::HeaderPosW'(cnep_pkg::MagicLen);
  assign field    = off[cnep_pkg::HeaderPosW-1:3];
  assign digit    = off[2:0];
  assign hv       = cnep_pkg::hex_value(byte_i);

  always_comb begin
    dec_o             = '0;
    dec_o.magic_bad   = in_magic && (byte_i != cnep_pkg::magic_char(pos_i[2:0]));
    dec_o.hex_bad     = hv[4];
    dec_o.nibble      = hv[3:0];
    dec_o.first_digit = digit == 3'd0;
    dec_o.last_digit  = digit == 3'(cnep_pkg::DigitsPerFld - 1);
    dec_o.fld         = cnep_pkg::FldMode;
    if (!in_magic) begin
      if (field == (cnep_pkg::HeaderPosW-3)'(cnep_pkg::FieldMode)) begin
        dec_o.hex_field = 1'b1;
        dec_o.fld       = cnep_pkg::FldMode;
      end else if (field == (cnep_pkg::HeaderPosW-3)'(cnep_pkg::FieldFileSize)) begin
        dec_o.hex_field = 1'b1;
        dec_o.fld       = cnep_pkg::FldFileSize;
      end else if (field == (cnep_pkg::HeaderPosW-3)'(cnep_pkg::FieldNameSize)) begin
        dec_o.hex_field = 1'b1;
        dec_o.fld       = cnep_pkg::FldNameSize;
      end
    end
  end

endmodule

### hw/rtl/cnep_name_cmp.sv
// ----------------------------------------------------------------------------
// cnep_name_cmp
// Compares one name byte against the configured target name and against
// the trailer name at the given name position.
// ----------------------------------------------------------------------------
module cnep_name_cmp (
  input  logic [cnep_pkg::NamePosW-1:0]   pos_i,
  input  logic [7:0]                      byte_i,
  input  logic [63:0]                     target_low_i,
  input  logic [63:0]                     target_high_i,
  input  logic [cnep_pkg::TargetLenW-1:0] target_len_i,
  output cnep_pkg::name_cmp_t             cmp_o
);

  logic [127:0] target;
  logic [7:0]   target_byte;
  logic [31:0]  pos_w;
  logic [31:0]  len_w;

  assign target      = {target_high_i, target_low_i};
  assign target_byte = target[{pos_i[3:0], 3'b000} +: 8];
  assign pos_w       = 32'(pos_i);
  assign len_w       = 32'(target_len_i);

  always_comb begin
    cmp_o = '0;
    // A target longer than the name buffer can never match.
    if (len_w > cnep_pkg::MaxNameBytes) begin
      cmp_o.target_miss = 1'b1;
    end else if (pos_w < len_w) begin
      cmp_o.target_miss = byte_i != target_byte;
    end else if (pos_w == len_w) begin
      cmp_o.target_miss = byte_i != 8'h00;
    end

    if (pos_w < cnep_pkg::TrailerLen) begin
      cmp_o.trailer_miss = byte_i != cnep_pkg::trailer_char(pos_i[3:0]);
    end else if (pos_w == cnep_pkg::TrailerLen) begin
      cmp_o.trailer_miss = byte_i != 8'h00;
    end
  end

endmodule

### hw/rtl/cnep_parser.sv
// ----------------------------------------------------------------------------
// cnep_parser
// Parse state of the archive walk. Each step consumes one byte, updates the
// phase, counters and decoded sizes, and produces the result for that byte.
// ----------------------------------------------------------------------------
module cnep_parser (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            step_i,
  input  logic [7:0]                      byte_i,
  input  logic                            start_i,
  input  logic [63:0]                     target_low_i,
  input  logic [63:0]                     target_high_i,
  input  logic [cnep_pkg::TargetLenW-1:0] target_len_i,
  output cnep_pkg::parse_res_t            res_o
);

  localparam int unsigned SW = cnep_pkg::SizeW;
  localparam int unsigned PW = cnep_pkg::HeaderPosW;
  localparam int unsigned AW = cnep_pkg::AlignW;
  localparam int unsigned NW = cnep_pkg::NamePosW;

  cnep_pkg::phase_e  ph_q, ph_d, c_ph;
  logic [PW-1:0]     pos_q, pos_d, c_pos;
  logic [SW-1:0]     acc_q, acc_d, c_acc;
  logic [SW-1:0]     nsz_q, nsz_d, c_nsz;
  logic [SW-1:0]     fsz_q, fsz_d, c_fsz;
  logic [3:0]        mode_q, mode_d, c_mode;
  logic [SW-1:0]     rem_q, rem_d, c_rem;
  logic [AW-1:0]     align_q, align_d, c_align;
  logic              tgt_q, tgt_d, c_tgt;
  logic              trl_q, trl_d, c_trl;
  cnep_pkg::status_e status_q, status_d, c_status;
  logic [NW-1:0]     npos_q, npos_d, c_npos;

  cnep_pkg::hdr_dec_t  dec;
  cnep_pkg::name_cmp_t cmp;

  logic          digit_ok;
  logic [SW-1:0] acc_new;
  logic [SW-1:0] nsz_new;
  logic [SW-1:0] fsz_new;
  logic [3:0]    mode_new;
  logic          hdr_last;
  logic          empty_name;
  logic [SW-1:0] rem_dec;
  logic          rem_zero;
  logic [AW-1:0] align_inc;
  logic          tgt_new;
  logic          trl_new;
  logic          name_last;
  logic          trailer_hit;
  logic          entry_match;

  // A start marker returns every state element to its reset value before
  // the byte is parsed.
  always_comb begin
    if (start_i) begin
      c_ph     = cnep_pkg::PhHeader;
      c_pos    = '0;
      c_acc    = '0;
      c_nsz    = '0;
      c_fsz    = '0;
      c_mode   = '0;
      c_rem    = '0;
      c_align  = '0;
      c_tgt    = 1'b1;
      c_trl    = 1'b1;
      c_status = cnep_pkg::StParsing;
      c_npos   = '0;
    end else begin
      c_ph     = ph_q;
      c_pos    = pos_q;
      c_acc    = acc_q;
      c_nsz    = nsz_q;
      c_fsz    = fsz_q;
      c_mode   = mode_q;
      c_rem    = rem_q;
      c_align  = align_q;
      c_tgt    = tgt_q;
      c_trl    = trl_q;
      c_status = status_q;
      c_npos   = npos_q;
    end
  end

  cnep_hdr_dec u_hdr_dec (
    .pos_i  (c_pos),
    .byte_i (byte_i),
    .dec_o  (dec)
  );

  cnep_name_cmp u_name_cmp (
    .pos_i         (c_npos),
    .byte_i        (byte_i),
    .target_low_i  (target_low_i),
    .target_high_i (target_high_i),
    .target_len_i  (target_len_i),
    .cmp_o         (cmp)
  );

  assign digit_ok = (c_ph == cnep_pkg::PhHeader) && !dec.magic_bad &&
                    dec.hex_field && !dec.hex_bad;
  assign acc_new  = dec.first_digit ? SW'(dec.nibble) : {c_acc[SW-5:0], dec.nibble};

  assign mode_new = (digit_ok && dec.last_digit && dec.fld == cnep_pkg::FldMode) ?
                    acc_new[15:12] : c_mode;
  assign fsz_new  = (digit_ok && dec.last_digit && dec.fld == cnep_pkg::FldFileSize) ?
                    acc_new : c_fsz;
  assign nsz_new  = (digit_ok && dec.last_digit && dec.fld == cnep_pkg::FldNameSize) ?
                    acc_new : c_nsz;

  assign hdr_last   = (c_ph == cnep_pkg::PhHeader) && !dec.magic_bad &&
                      !(dec.hex_field && dec.hex_bad) &&
                      (c_pos == PW'(cnep_pkg::HeaderBytes - 1));
  assign empty_name = nsz_new == '0;

  assign rem_dec   = c_rem - 1'b1;
  assign rem_zero  = rem_dec == '0;
  assign align_inc = c_align + 1'b1;

  assign tgt_new     = c_tgt && !cmp.target_miss;
  assign trl_new     = c_trl && !cmp.trailer_miss;
  assign name_last   = (c_ph == cnep_pkg::PhName) && rem_zero;
  assign trailer_hit = name_last && trl_new && (c_nsz > SW'(cnep_pkg::TrailerLen));
  assign entry_match = tgt_new && (c_nsz > SW'(target_len_i));

  // Next state.
  always_comb begin
    ph_d     = c_ph;
    pos_d    = c_pos;
    acc_d    = c_acc;
    nsz_d    = nsz_new;
    fsz_d    = fsz_new;
    mode_d   = mode_new;
    rem_d    = c_rem;
    align_d  = c_align;
    tgt_d    = c_tgt;
    trl_d    = c_trl;
    status_d = c_status;
    npos_d   = c_npos;
    unique case (c_ph)
      cnep_pkg::PhHeader: begin
        if (dec.magic_bad) begin
          ph_d     = cnep_pkg::PhStop;
          status_d = cnep_pkg::StBadMagic;
        end else if (dec.hex_field && dec.hex_bad) begin
          ph_d     = cnep_pkg::PhStop;
          status_d = cnep_pkg::StBadHex;
        end else begin
          if (dec.hex_field) begin
            acc_d = acc_new;
          end
          if (hdr_last) begin
            pos_d   = '0;
            align_d = cnep_pkg::HeaderAlign;
            tgt_d   = 1'b1;
            trl_d   = 1'b1;
            npos_d  = '0;
            if (!empty_name) begin
              ph_d  = cnep_pkg::PhName;
              rem_d = nsz_new;
            end else if (cnep_pkg::HeaderAlign != '0) begin
              ph_d = cnep_pkg::PhNamePad;
            end else if (fsz_new == '0) begin
              ph_d    = cnep_pkg::PhHeader;
              align_d = '0;
            end else begin
              ph_d  = cnep_pkg::PhData;
              rem_d = fsz_new;
            end
          end else begin
            pos_d = c_pos + 1'b1;
          end
        end
      end
      cnep_pkg::PhName: begin
        tgt_d   = tgt_new;
        trl_d   = trl_new;
        rem_d   = rem_dec;
        align_d = align_inc;
        if (c_npos != NW'(cnep_pkg::NameCmpLen)) begin
          npos_d = c_npos + 1'b1;
        end
        if (rem_zero) begin
          if (trailer_hit) begin
            ph_d     = cnep_pkg::PhStop;
            status_d = cnep_pkg::StTrailer;
          end else if (align_inc != '0) begin
            ph_d = cnep_pkg::PhNamePad;
          end else if (c_fsz == '0) begin
            ph_d    = cnep_pkg::PhHeader;
            pos_d   = '0;
            align_d = '0;
          end else begin
            ph_d  = cnep_pkg::PhData;
            rem_d = c_fsz;
          end
        end
      end
      cnep_pkg::PhNamePad: begin
        align_d = align_inc;
        if (align_inc == '0) begin
          if (c_fsz == '0) begin
            ph_d  = cnep_pkg::PhHeader;
            pos_d = '0;
          end else begin
            ph_d  = cnep_pkg::PhData;
            rem_d = c_fsz;
          end
        end
      end
      cnep_pkg::PhData: begin
        rem_d   = rem_dec;
        align_d = align_inc;
        if (rem_zero) begin
          if (align_inc == '0) begin
            ph_d  = cnep_pkg::PhHeader;
            pos_d = '0;
          end else begin
            ph_d = cnep_pkg::PhDataPad;
          end
        end
      end
      cnep_pkg::PhDataPad: begin
        align_d = align_inc;
        if (align_inc == '0) begin
          ph_d  = cnep_pkg::PhHeader;
          pos_d = '0;
        end
      end
      cnep_pkg::PhStop: begin
        ph_d = cnep_pkg::PhStop;
      end
      default: begin
        ph_d = c_ph;
      end
    endcase
  end

  // Result for the byte.
  always_comb begin
    res_o              = '0;
    res_o.data_byte    = byte_i;
    res_o.file_size    = fsz_new;
    res_o.name_size    = nsz_new;
    res_o.status       = status_d;
    res_o.entry_done   = (hdr_last && empty_name) || name_last;
    res_o.name_match   = name_last && !trailer_hit && entry_match;
    res_o.is_directory = ((hdr_last && empty_name) || (name_last && !trailer_hit)) &&
                         (mode_new == cnep_pkg::ModeTypeDir);
    unique case (c_ph)
      cnep_pkg::PhHeader:  res_o.cls = cnep_pkg::ClsHeader;
      cnep_pkg::PhName:    res_o.cls = cnep_pkg::ClsName;
      cnep_pkg::PhNamePad: res_o.cls = cnep_pkg::ClsNamePad;
      cnep_pkg::PhData:    res_o.cls = cnep_pkg::ClsData;
      cnep_pkg::PhDataPad: res_o.cls = cnep_pkg::ClsDataPad;
      default:             res_o.cls = cnep_pkg::ClsIgnored;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ph_q     <= cnep_pkg::PhHeader;
      pos_q    <= '0;
      acc_q    <= '0;
      nsz_q    <= '0;
      fsz_q    <= '0;
      mode_q   <= '0;
      rem_q    <= '0;
      align_q  <= '0;
      tgt_q    <= 1'b1;
      trl_q    <= 1'b1;
      status_q <= cnep_pkg::StParsing;
      npos_q   <= '0;
    end else if (step_i) begin
      ph_q     <= ph_d;
      pos_q    <= pos_d;
      acc_q    <= acc_d;
      nsz_q    <= nsz_d;
      fsz_q    <= fsz_d;
      mode_q   <= mode_d;
      rem_q    <= rem_d;
      align_q  <= align_d;
      tgt_q    <= tgt_d;
      trl_q    <= trl_d;
      status_q <= status_d;
      npos_q   <= npos_d;
    end
  end

endmodule

### hw/rtl/cpio_newc_entry_parser.sv
// ----------------------------------------------------------------------------
// cpio_newc_entry_parser
// Walks a cpio newc archive one byte per transaction, classifies each byte,
// decodes entry sizes and reports target name matches.
// ----------------------------------------------------------------------------
//
// Channel   Direction  tdata                          tuser
// s_axis    in         archive_byte                   archive_start
// m_axis    out        data_byte, flags, sizes, st.   byte_class
// cfg       in         target name words and length   -
//
// Each byte passes an input register and a result register; one byte per
// cycle is sustained while the result is taken. The parse state is updated in the
// cycle in which a byte moves from the input register to the result
// register. When the result is not taken, the input register still accepts
// one more byte. Reset clears the parse state and target registers.
module cpio_newc_entry_parser (
  input  logic        clk_i,
  input  logic        rst_ni,
  // archive_byte [7:0]
  input  logic [7:0]  s_axis_tdata_i,
  // archive_start [0]
  input  logic [0:0]  s_axis_tuser_i,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // data_byte [7:0], entry_done [8], name_match [9], is_directory [10],
  // file_size [42:11], name_size [74:43], status [76:75], zero fill [79:77]
  output logic [79:0] m_axis_tdata_o,
  // byte_class [2:0]
  output logic [2:0]  m_axis_tuser_o,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [63:0] cfg_data_i
);

  logic                            in_valid_q;
  logic [7:0]                      in_byte_q;
  logic                            in_start_q;
  logic                            out_valid_q;
  cnep_pkg::parse_res_t            out_q;
  cnep_pkg::parse_res_t            res;
  logic                            advance;
  logic [63:0]                     tgt_low_q;
  logic [63:0]                     tgt_high_q;
  logic [cnep_pkg::TargetLenW-1:0] tgt_len_q;

  assign advance         = in_valid_q && (!out_valid_q || m_axis_tready_i);
  assign s_axis_tready_o = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tgt_low_q  <= '0;
      tgt_high_q <= '0;
      tgt_len_q  <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        cnep_pkg::CfgTargetLow:  tgt_low_q  <= cfg_data_i;
        cnep_pkg::CfgTargetHigh: tgt_high_q <= cfg_data_i;
        cnep_pkg::CfgTargetLen:  tgt_len_q  <= cfg_data_i[cnep_pkg::TargetLenW-1:0];
        default: begin
          tgt_len_q <= tgt_len_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      in_valid_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready_o && s_axis_tvalid_i) begin
      in_byte_q  <= s_axis_tdata_i;
      in_start_q <= s_axis_tuser_i[0];
    end
  end

  cnep_parser u_parser (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .step_i        (advance),
    .byte_i        (in_byte_q),
    .start_i       (in_start_q),
    .target_low_i  (tgt_low_q),
    .target_high_i (tgt_high_q),
    .target_len_i  (tgt_len_q),
    .res_o         (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (!out_valid_q || m_axis_tready_i) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tuser_o  = out_q.cls;
  assign m_axis_tdata_o  = {3'b000, out_q.status, out_q.name_size, out_q.file_size,
                            out_q.is_directory, out_q.name_match, out_q.entry_done,
                            out_q.data_byte};

  // Match and directory flags only accompany a finished entry.
  a_flags_need_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_q.entry_done) |-> (!out_q.name_match && !out_q.is_directory))
    else $error("match or directory flag without entry_done");

  // Ignored bytes only appear after parsing has stopped.
  a_ignored_stopped: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.cls == cnep_pkg::ClsIgnored) |-> (out_q.status != cnep_pkg::StParsing))
    else $error("ignored byte while status is parsing");

  // The trailer stop is reported on the last name byte.
  a_trailer_on_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.cls == cnep_pkg::ClsName && out_q.status == cnep_pkg::StTrailer)
      |-> (out_q.entry_done && !out_q.name_match))
    else $error("trailer status on a name byte that does not end the entry");

  // Both stages full and the result stalled: no new byte may enter.
  a_full_backpressure: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_q && out_valid_q && !m_axis_tready_i) |-> !s_axis_tready_o)
    else $error("input accepted while the pipeline is full and stalled");

endmodule

### tb/tb_cpio_newc_entry_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_cpio_newc_entry_parser
// Self-checking bench for the cpio newc entry parser. Hand-built archives
// exercise the magic and hex checks, padding, empty names, the trailer and
// target matching. Random archives with faults, restarts and noise follow.
// Every output byte is compared against a behavioral model of the parser.
// ----------------------------------------------------------------------------
module tb_cpio_newc_entry_parser;
  import cnep_pkg::*;

  localparam int unsigned StallLimit = 2000;
  localparam int unsigned NumFields  = (HeaderBytes - MagicLen) / DigitsPerFld;
  localparam logic [47:0] MagicStr   = "070701";
  localparam logic [79:0] TrailerStr = "TRAILER!!!";
  localparam logic [31:0] ModeDir    = 32'h0000_41ED;
  localparam logic [31:0] ModeFile   = 32'h0000_81A4;

  typedef enum int unsigned {
    FaultNone,
    FaultMagic,
    FaultHex
  } fault_e;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic [7:0]  s_tdata;
  logic [0:0]  s_tuser;
  logic        s_tvalid;
  logic        s_axis_tready_o;
  logic [79:0] m_axis_tdata_o;
  logic [2:0]  m_axis_tuser_o;
  logic        m_axis_tvalid_o;
  logic        m_tready;
  logic        cfg_we;
  logic [1:0]  cfg_idx;
  logic [63:0] cfg_data;

  // Returns {invalid, value} for one ASCII character.
  function automatic logic [4:0] nibble_of(logic [7:0] c);
    if (c >= "0" && c <= "9") return {1'b0, 4'(c - "0")};
    if (c >= "A" && c <= "F") return {1'b0, 4'(c - "A" + 8'd10)};
    if (c >= "a" && c <= "f") return {1'b0, 4'(c - "a" + 8'd10)};
    return 5'h10;
  endfunction

  class cpio_parse_scoreboard;
    logic [63:0] tgt_low;
    logic [63:0] tgt_high;
    logic [4:0]  tgt_len;
    phase_e      phase;
    int unsigned hdr_pos;
    logic [31:0] hex_acc;
    logic [31:0] name_size;
    logic [31:0] file_size;
    logic [31:0] remaining;
    logic [3:0]  mode_type;
    logic [1:0]  align;
    bit          tgt_ok;
    bit          trl_ok;
    status_e     stop_st;
    parse_res_t  pending_results[$];
    int unsigned errors;
    int unsigned checked;

    function new();
      tgt_low  = '0;
      tgt_high = '0;
      tgt_len  = '0;
      errors   = 0;
      checked  = 0;
      restart();
    endfunction

    function void restart();
      phase     = PhHeader;
      hdr_pos   = 0;
      hex_acc   = '0;
      name_size = '0;
      file_size = '0;
      mode_type = '0;
      remaining = '0;
      align     = '0;
      tgt_ok    = 1'b1;
      trl_ok    = 1'b1;
      stop_st   = StParsing;
    endfunction

    function void set_reg(cfg_index_e idx, logic [63:0] val);
      case (idx)
        CfgTargetLow:  tgt_low = val;
        CfgTargetHigh: tgt_high = val;
        default:       tgt_len = val[4:0];
      endcase
    endfunction

    function logic [7:0] target_char(int unsigned p);
      if (p < 8) return tgt_low[8*p +: 8];
      return tgt_high[8*(p-8) +: 8];
    endfunction

    function void halt(status_e code);
      stop_st = code;
      phase   = PhStop;
    endfunction

    function void next_header();
      phase   = PhHeader;
      hdr_pos = 0;
      align   = '0;
    endfunction

    function void enter_data();
      if (file_size == 0) begin
        next_header();
      end else begin
        phase     = PhData;
        remaining = file_size;
      end
    endfunction

    function void leave_name();
      if (align != 0) phase = PhNamePad;
      else enter_data();
    endfunction

    // Predicts the result of one accepted archive byte and queues it.
    function void note_archive_byte(logic [7:0] b, logic start);
      parse_res_t  r;
      int unsigned fld;
      int unsigned dig;
      logic [4:0]  nib;
      logic [31:0] p;
      r = '0;
      r.cls = ClsIgnored;
      r.data_byte = b;
      if (start) restart();
      case (phase)
        PhHeader: begin
          r.cls = ClsHeader;
          if (hdr_pos < MagicLen) begin
            if (b != MagicStr[8*(MagicLen-1-hdr_pos) +: 8]) halt(StBadMagic);
          end else begin
            fld = (hdr_pos - MagicLen) / DigitsPerFld;
            dig = (hdr_pos - MagicLen) % DigitsPerFld;
            if (fld == FieldMode || fld == FieldFileSize || fld == FieldNameSize) begin
              nib = nibble_of(b);
              if (nib[4]) begin
                halt(StBadHex);
              end else begin
                hex_acc = (dig == 0) ? {28'h0, nib[3:0]} : {hex_acc[27:0], nib[3:0]};
                if (dig == DigitsPerFld - 1) begin
                  if (fld == FieldMode) mode_type = hex_acc[15:12];
                  else if (fld == FieldFileSize) file_size = hex_acc;
                  else name_size = hex_acc;
                end
              end
            end
          end
          if (phase == PhHeader) begin
            if (hdr_pos == HeaderBytes - 1) begin
              hdr_pos = 0;
              align   = HeaderAlign;
              tgt_ok  = 1'b1;
              trl_ok  = 1'b1;
              if (name_size == 0) begin
                // An empty name completes the entry on the last header byte.
                r.entry_done   = 1'b1;
                r.is_directory = (mode_type == ModeTypeDir);
                leave_name();
              end else begin
                phase     = PhName;
                remaining = name_size;
              end
            end else begin
              hdr_pos++;
            end
          end
        end
        PhName: begin
          r.cls = ClsName;
          p = name_size - remaining;
          if (tgt_len > MaxNameBytes) begin
            tgt_ok = 1'b0;
          end else if (p < tgt_len) begin
            if (b != target_char(p)) tgt_ok = 1'b0;
          end else if (p == tgt_len && b != 8'h00) begin
            tgt_ok = 1'b0;
          end
          if (p < TrailerLen) begin
            if (b != TrailerStr[8*(TrailerLen-1-p) +: 8]) trl_ok = 1'b0;
          end else if (p == TrailerLen && b != 8'h00) begin
            trl_ok = 1'b0;
          end
          remaining--;
          align++;
          if (remaining == 0) begin
            r.entry_done = 1'b1;
            if (trl_ok && name_size > TrailerLen) begin
              halt(StTrailer);
            end else begin
              r.name_match   = tgt_ok && (name_size > tgt_len);
              r.is_directory = (mode_type == ModeTypeDir);
              leave_name();
            end
          end
        end
        PhNamePad: begin
          r.cls = ClsNamePad;
          align++;
          if (align == 0) enter_data();
        end
        PhData: begin
          r.cls = ClsData;
          remaining--;
          align++;
          if (remaining == 0) begin
            if (align == 0) next_header();
            else phase = PhDataPad;
          end
        end
        PhDataPad: begin
          r.cls = ClsDataPad;
          align++;
          if (align == 0) next_header();
        end
        default: begin
        end
      endcase
      r.file_size = file_size;
      r.name_size = name_size;
      r.status    = stop_st;
      pending_results.push_back(r);
    endfunction

    task report(string msg);
      errors++;
      $display("MISMATCH: %s", msg);
    endtask

    task compare(string field, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
        report($sformatf("byte %0d %s: expected %0h, got %0h", checked, field, want, got));
      end
    endtask

    task check_result(logic [79:0] td, logic [2:0] tu);
      parse_res_t e;
      if (pending_results.size() == 0) begin
        report($sformatf("result %0h/%0h with no byte outstanding", tu, td));
      end else begin
        e = pending_results.pop_front();
        compare("byte_class", e.cls, tu);
        compare("data_byte", e.data_byte, td[7:0]);
        compare("entry_done", e.entry_done, td[8]);
        compare("name_match", e.name_match, td[9]);
        compare("is_directory", e.is_directory, td[10]);
        compare("file_size", e.file_size, td[42:11]);
        compare("name_size", e.name_size, td[74:43]);
        compare("status", e.status, td[76:75]);
        checked++;
      end
    endtask
  endclass

  cpio_parse_scoreboard sb;
  logic [8:0]  stim_q[$];
  logic [7:0]  name_buf[$];
  bit          start_next;
  bit          tx_gaps;
  bit          rx_gaps;
  int unsigned sent_bytes;
  int unsigned stall_cycles;

  cpio_newc_entry_parser dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tuser_i  (s_tuser),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_axis_tready_o),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_tready),
    .cfg_we_i        (cfg_we),
    .cfg_idx_i       (cfg_idx),
    .cfg_data_i      (cfg_data)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  function automatic void put_byte(logic [7:0] b);
    stim_q.push_back({start_next, b});
    start_next = 1'b0;
  endfunction

  function automatic logic [7:0] rand_byte();
    case ($urandom_range(0, 7))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // Eight hex digits, most significant first, in random letter case.
  function automatic void put_hex(logic [31:0] v);
    logic [3:0] d;
    for (int i = 7; i >= 0; i--) begin
      d = v[4*i +: 4];
      if (d < 10) put_byte(8'h30 + d);
      else put_byte(($urandom_range(0, 1) ? 8'h41 : 8'h61) + d - 8'd10);
    end
  endfunction

  // Appends a full entry whose name is name_buf, optionally with one fault.
  function automatic void put_entry(logic [31:0] mode, logic [31:0] fsize, fault_e fault);
    int unsigned base;
    int unsigned pos;
    logic [7:0]  bad;
    logic [4:0]  nib;
    base = stim_q.size();
    for (int i = 0; i < MagicLen; i++) put_byte(MagicStr[8*(MagicLen-1-i) +: 8]);
    for (int f = 0; f < NumFields; f++) begin
      if (f == FieldMode) begin
        put_hex(mode);
      end else if (f == FieldFileSize) begin
        put_hex(fsize);
      end else if (f == FieldNameSize) begin
        put_hex(name_buf.size());
      end else if ($urandom_range(0, 3) == 0) begin
        // Unchecked fields may hold anything.
        repeat (DigitsPerFld) put_byte(rand_byte());
      end else begin
        put_hex($urandom());
      end
    end
    if (fault == FaultMagic) begin
      pos = base + $urandom_range(0, MagicLen - 1);
      do bad = rand_byte(); while (bad == stim_q[pos][7:0]);
      stim_q[pos] = {stim_q[pos][8], bad};
    end else if (fault == FaultHex) begin
      case ($urandom_range(0, 2))
        0:       pos = FieldMode;
        1:       pos = FieldFileSize;
        default: pos = FieldNameSize;
      endcase
      pos = base + MagicLen + DigitsPerFld * pos + $urandom_range(0, DigitsPerFld - 1);
      do begin
        bad = rand_byte();
        nib = nibble_of(bad);
      end while (!nib[4]);
      stim_q[pos] = {stim_q[pos][8], bad};
    end
    foreach (name_buf[i]) put_byte(name_buf[i]);
    repeat ((4 - (HeaderBytes + name_buf.size()) % 4) % 4) put_byte(rand_byte());
    for (int unsigned i = 0; i < fsize; i++) put_byte(rand_byte());
    repeat ((4 - fsize % 4) % 4) put_byte(rand_byte());
  endfunction

  function automatic void name_from_text(string s, bit term);
    name_buf.delete();
    for (int i = 0; i < s.len(); i++) name_buf.push_back(s.getc(i));
    if (term) name_buf.push_back(8'h00);
  endfunction

  function automatic void name_from_target(int unsigned len);
    name_buf.delete();
    for (int unsigned i = 0; i < len; i++) name_buf.push_back(sb.target_char(i));
    name_buf.push_back(8'h00);
  endfunction

  // Drives every queued byte; each task call starts and ends at a falling edge.
  task automatic send_stim();
    logic [8:0] item;
    while (stim_q.size() != 0) begin
      item = stim_q.pop_front();
      while (tx_gaps && $urandom_range(0, 99) < 11) begin
        s_tvalid <= 1'b0;
        @(negedge clk_i);
      end
      s_tvalid <= 1'b1;
      s_tdata  <= item[7:0];
      s_tuser  <= item[8];
      do @(posedge clk_i); while (!s_axis_tready_o);
      sb.note_archive_byte(item[7:0], item[8]);
      sent_bytes++;
      @(negedge clk_i);
    end
  endtask

  task automatic drain_parser();
    s_tvalid <= 1'b0;
    while (sb.pending_results.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic load_target(logic [63:0] lo, logic [63:0] hi, logic [4:0] len);
    cfg_we   <= 1'b1;
    cfg_idx  <= CfgTargetLow;
    cfg_data <= lo;
    @(negedge clk_i);
    cfg_idx  <= CfgTargetHigh;
    cfg_data <= hi;
    @(negedge clk_i);
    cfg_idx  <= CfgTargetLen;
    cfg_data <= {59'h0, len};
    @(negedge clk_i);
    cfg_we   <= 1'b0;
    sb.set_reg(CfgTargetLow, lo);
    sb.set_reg(CfgTargetHigh, hi);
    sb.set_reg(CfgTargetLen, {59'h0, len});
  endtask

  task automatic random_target(int unsigned kind);
    logic [63:0] lo;
    logic [63:0] hi;
    logic [4:0]  len;
    for (int i = 0; i < 8; i++) begin
      lo[8*i +: 8] = 8'($urandom_range(8'h21, 8'h7E));
      hi[8*i +: 8] = 8'($urandom_range(8'h21, 8'h7E));
    end
    len = 5'($urandom_range(1, MaxNameBytes));
    case (kind % 5)
      0: begin
        lo  = '0;
        hi  = '0;
        len = '0;
      end
      1: begin
        lo  = '1;
        hi  = '1;
        len = 5'(MaxNameBytes);
      end
      2: len = 5'($urandom_range(MaxNameBytes + 1, 31));
      3: begin
        lo = {$urandom(), $urandom()};
        hi = {$urandom(), $urandom()};
      end
      default: begin
      end
    endcase
    load_target(lo, hi, len);
  endtask

  // One archive of a few entries, mostly well formed, sometimes cut short.
  task automatic random_archive();
    int unsigned entries;
    int unsigned tlen;
    int unsigned pick;
    fault_e      fault;
    logic [31:0] mode;
    logic [31:0] fsize;
    tlen = (sb.tgt_len > MaxNameBytes) ? MaxNameBytes : sb.tgt_len;
    start_next = 1'b1;
    fault = FaultNone;
    entries = $urandom_range(1, 4);
    for (int e = 0; e < entries && fault == FaultNone; e++) begin
      case ($urandom_range(0, 9))
        0, 1, 2: name_from_target(tlen);
        3: begin
          name_from_target(tlen);
          repeat ($urandom_range(1, 3)) name_buf.push_back(rand_byte());
        end
        4: begin
          name_from_target(tlen);
          pick = $urandom_range(0, name_buf.size() - 1);
          name_buf[pick] = name_buf[pick] ^ (8'h01 << $urandom_range(0, 7));
        end
        5: name_from_text("TRAILER!!!", $urandom_range(0, 1));
        6: name_buf.delete();
        default: begin
          name_buf.delete();
          repeat ($urandom_range(0, 20)) name_buf.push_back(8'($urandom_range(1, 255)));
          name_buf.push_back(8'h00);
        end
      endcase
      mode  = ($urandom_range(0, 2) == 0) ? ModeDir : $urandom();
      fsize = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 40) : $urandom_range(0, 9);
      pick  = $urandom_range(0, 99);
      if (pick < 6) fault = FaultMagic;
      else if (pick < 12) fault = FaultHex;
      put_entry(mode, fsize, fault);
    end
    if (fault == FaultNone && $urandom_range(0, 1) == 1) begin
      name_from_text("TRAILER!!!", 1'b1);
      put_entry($urandom(), 32'd0, FaultNone);
      repeat ($urandom_range(0, 6)) put_byte(rand_byte());
    end
    // A cut archive makes the next start flag land in the middle of an entry.
    if ($urandom_range(0, 7) == 0) begin
      repeat ($urandom_range(1, 40)) begin
        if (stim_q.size() > 1) void'(stim_q.pop_back());
      end
    end
    send_stim();
  endtask

  task automatic noise_burst();
    start_next = $urandom_range(0, 1);
    repeat ($urandom_range(8, 30)) begin
      if ($urandom_range(0, 7) == 0) start_next = 1'b1;
      put_byte(rand_byte());
    end
    send_stim();
  endtask

  always @(negedge clk_i) begin
    m_tready <= rx_gaps ? ($urandom_range(0, 99) >= 11) : 1'b1;
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid_o && m_tready) sb.check_result(m_axis_tdata_o, m_axis_tuser_o);
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stall_cycles <= 0;
    end else if ((s_tvalid && s_axis_tready_o) || (m_axis_tvalid_o && m_tready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    wait (stall_cycles >= StallLimit);
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    int unsigned phase_start;
    sb         = new();
    rst_ni     = 1'b0;
    s_tdata    = '0;
    s_tuser    = '0;
    s_tvalid   = 1'b0;
    m_tready   = 1'b0;
    cfg_we     = 1'b0;
    cfg_idx    = CfgTargetLow;
    cfg_data   = '0;
    tx_gaps    = 1'b1;
    rx_gaps    = 1'b1;
    start_next = 1'b0;
    sent_bytes = 0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Target "hello.txt", byte zero in the lowest bits.
    load_target(64'h7874_2E6F_6C6C_6568, 64'h0000_0000_0000_0074, 5'd9);
    start_next = 1'b1;
    name_from_text("hello.txt", 1'b1);
    put_entry(ModeFile, 32'd5, FaultNone);
    name_from_text("hello.txt.bak", 1'b1);
    put_entry(ModeFile, 32'd0, FaultNone);
    name_from_text("etc", 1'b1);
    put_entry(ModeDir, 32'd0, FaultNone);
    name_buf.delete();
    put_entry(32'h0000_4000, 32'd3, FaultNone);
    // Bytes past the terminator do not affect the match.
    name_from_text("hello.txt", 1'b1);
    name_buf.push_back("j");
    put_entry(32'hFFFF_FFFF, 32'd8, FaultNone);
    // One character short of the trailer name, so parsing continues.
    name_from_text("TRAILER!!", 1'b1);
    put_entry(ModeFile, 32'd1, FaultNone);
    name_from_text("TRAILER!!!", 1'b1);
    put_entry(32'h0, 32'd0, FaultNone);
    repeat (4) put_byte(8'hA5);
    send_stim();

    start_next = 1'b1;
    name_from_text("a", 1'b1);
    put_entry(ModeFile, 32'd1, FaultMagic);
    send_stim();
    start_next = 1'b1;
    put_entry(ModeFile, 32'd1, FaultHex);
    send_stim();

    // A new archive starts four bytes into a name.
    start_next = 1'b1;
    name_from_text("interrupted", 1'b1);
    put_entry(ModeFile, 32'd2, FaultNone);
    repeat (14) void'(stim_q.pop_back());
    start_next = 1'b1;
    name_from_text("hello.txt", 1'b1);
    put_entry(ModeDir, 32'd0, FaultNone);
    send_stim();

    drain_parser();
    load_target('1, '1, 5'(MaxNameBytes));
    start_next = 1'b1;
    name_from_target(MaxNameBytes);
    put_entry(ModeDir, 32'd0, FaultNone);
    send_stim();
    drain_parser();
    load_target('1, '1, 5'(MaxNameBytes + 1));
    start_next = 1'b1;
    name_from_target(MaxNameBytes);
    put_entry(ModeDir, 32'd0, FaultNone);
    send_stim();
    drain_parser();
    load_target('0, '0, '0);
    start_next = 1'b1;
    name_from_text("", 1'b1);
    put_entry(ModeFile, 32'd4, FaultNone);
    name_from_text("x", 1'b1);
    put_entry(ModeFile, 32'd0, FaultNone);
    send_stim();

    for (int ph = 0; ph < 6; ph++) begin
      drain_parser();
      random_target(ph);
      // The second phase runs without any idle cycles on either side.
      tx_gaps = (ph != 1);
      rx_gaps = (ph != 1);
      phase_start = sent_bytes;
      while (sent_bytes - phase_start < 200) begin
        if ($urandom_range(0, 9) == 0) noise_burst();
        else random_archive();
      end
    end

    drain_parser();
    repeat (8) @(negedge clk_i);
    if (sb.errors == 0 && sb.pending_results.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

### filelist.f
hw/rtl/cnep_pkg.sv
hw/rtl/cnep_hdr_dec.sv
hw/rtl/cnep_name_cmp.sv
hw/rtl/cnep_parser.sv
hw/rtl/cpio_newc_entry_parser.sv
tb/tb_cpio_newc_entry_parser.sv
